[hdl/urp_pkg.sv]
// Shared types, constants and codes for the USB audio ring packetizer.
// Depends on nothing; every other file of the block imports it.
package urp_pkg;

    // FIFO geometry.
    localparam int DEPTH  = 256;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CAP_W  = $clog2(DEPTH + 1);

    // Packet geometry.
    localparam int CHANNELS         = 2;
    localparam int BYTES_PER_FRAME  = CHANNELS * 3;
    localparam int MAX_PACKET_BYTES = 294;
    localparam int MAX_FRAMES       = 48;
    localparam int FRAMES_W         = 6;
    localparam int BYTES_W          = 10;

    // Supported stream rates and their frame counts per USB frame.
    localparam logic [17:0] RATE_44K = 18'd44100;
    localparam logic [17:0] RATE_48K = 18'd48000;
    localparam logic [FRAMES_W-1:0] FRAMES_44K_SHORT = 6'd44;
    localparam logic [FRAMES_W-1:0] FRAMES_44K_LONG  = 6'd45;
    localparam logic [FRAMES_W-1:0] FRAMES_48K       = 6'd48;

    // 24-bit sample limits.
    localparam logic signed [23:0] S24_MAX = 24'sd8388607;
    localparam logic signed [23:0] S24_MIN = -24'sd8388608;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_CAP    = 1'd1;

    // Command queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [0:0] {
        OP_PUSH   = 1'b0,
        OP_RENDER = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] sample_ch0;
        logic signed [31:0] sample_ch1;
        logic [63:0]        usb_frame_sequence;
        logic [9:0]         packet_capacity;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic               status;
        logic               zero_filled;
        logic               last_of_packet;
        logic [8:0]         fill_level;
        logic [31:0]        overrun_count;
        logic [31:0]        underrun_count;
    } t_out_item;

    // A classified command, as the back part executes it.
    typedef struct packed {
        t_opcode             opcode;
        logic                reject;
        logic [FRAMES_W-1:0] frames;
        logic signed [23:0]  left;
        logic signed [23:0]  right;
    } t_cmd;

    // Ring settings handed to the back part.
    typedef struct packed {
        logic [CAP_W-1:0] cap;
        logic             clear;
    } t_back_cfg;

endpackage

[hdl/urp_front.sv]
// Front part of the USB audio ring packetizer: accepts items and classifies them.
// Converts pushed samples to 24 bits and sizes render requests. Depends on urp_pkg.
module urp_front import urp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic [17:0] i_sample_rate,
    input  logic        i_q_full,
    output logic        o_valid,
    output t_cmd        o_cmd
);

    // Q8.24 to signed 24 bits: halve with rounding away from zero, saturate.
    function automatic logic signed [23:0] to_s24(input logic signed [31:0] x);
        logic signed [32:0] r;
        r = 33'sd0;
        if (x >= 32'sd16777216) begin
            return S24_MAX;
        end
        if (x <= -32'sd16777216) begin
            return S24_MIN;
        end
        if (x >= 32'sd0) begin
            r = ($signed({x[31], x}) + 33'sd1) >>> 1;
        end else begin
            r = $signed({x[31], x}) >>> 1;
        end
        if (r > 33'sd8388607) begin
            return S24_MAX;
        end
        return r[23:0];
    endfunction

    // Residue modulo 5 of a 64-bit value; 256 and 16 are both 1 modulo 5.
    function automatic logic [2:0] mod5(input logic [63:0] n);
        logic [10:0] acc;
        logic [8:0]  fold;
        logic [4:0]  v;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + 11'(n[8*i +: 8]);
        end
        fold = 9'(acc[10:8]) + 9'(acc[7:0]);
        v = 5'(fold[8]) + 5'(fold[7:4]) + 5'(fold[3:0]);
        if (v >= 5'd30) begin
            v = v - 5'd30;
        end else if (v >= 5'd25) begin
            v = v - 5'd25;
        end else if (v >= 5'd20) begin
            v = v - 5'd20;
        end else if (v >= 5'd15) begin
            v = v - 5'd15;
        end else if (v >= 5'd10) begin
            v = v - 5'd10;
        end else if (v >= 5'd5) begin
            v = v - 5'd5;
        end
        return v[2:0];
    endfunction

    logic                r_valid;
    t_cmd                r_cmd;
    t_cmd                n_cmd;
    logic                rate_ok;
    logic [FRAMES_W-1:0] frames;
    logic [BYTES_W-1:0]  bytes;

    // At 44.1 kHz the packet is one frame longer when the USB frame number ends in 9.
    always_comb begin
        rate_ok = 1'b1;
        frames  = '0;
        if (i_sample_rate == RATE_48K) begin
            frames = FRAMES_48K;
        end else if (i_sample_rate == RATE_44K) begin
            if (i_item.usb_frame_sequence[0] && mod5(i_item.usb_frame_sequence) == 3'd4) begin
                frames = FRAMES_44K_LONG;
            end else begin
                frames = FRAMES_44K_SHORT;
            end
        end else begin
            rate_ok = 1'b0;
        end
        bytes = BYTES_W'(frames) * BYTES_W'(BYTES_PER_FRAME);

        n_cmd.opcode = i_item.opcode;
        n_cmd.frames = frames;
        n_cmd.reject = !rate_ok || frames == '0
                    || bytes > i_item.packet_capacity
                    || 32'(bytes) > MAX_PACKET_BYTES
                    || 32'(frames) > MAX_FRAMES;
        n_cmd.left   = to_s24(i_item.sample_ch0);
        n_cmd.right  = to_s24(i_item.sample_ch1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

[hdl/urp_queue.sv]
// Short command queue that decouples the front part from the back part.
// Depends on urp_pkg for the command type and queue depth.
module urp_queue import urp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QDEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QDEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hdl/urp_back.sv]
// Back part of the USB audio ring packetizer: frame memory, ring pointers and counters.
// Executes queued pushes and renders and drives the result strobe. Depends on urp_pkg.
module urp_back import urp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_back_cfg i_cfg,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_valid,
    output t_out_item o_result
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_RENDER = 2'b10
    } t_back_state;

    logic [47:0]         r_frame_mem [DEPTH];
    logic [47:0]         r_rd_data;

    t_back_state         r_state,   n_state;
    logic [IDX_W-1:0]    r_wr_idx,  n_wr_idx;
    logic [IDX_W-1:0]    r_rd_idx,  n_rd_idx;
    logic [CAP_W-1:0]    r_held,    n_held;
    logic [31:0]         r_over,    n_over;
    logic [31:0]         r_under,   n_under;
    logic [FRAMES_W-1:0] r_left,    n_left;

    logic                r_out_valid,   n_out_valid;
    logic                r_out_status,  n_out_status;
    logic                r_out_zf,      n_out_zf;
    logic                r_out_last,    n_out_last;
    logic                r_out_mem,     n_out_mem;
    logic [CAP_W-1:0]    r_out_fill,    n_out_fill;
    logic [31:0]         r_out_over,    n_out_over;
    logic [31:0]         r_out_under,   n_out_under;

    logic                mem_we;
    logic                mem_re;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                  input logic [CAP_W-1:0] cap);
        if (CAP_W'(idx) + 1'b1 == cap) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    always_comb begin
        n_state      = r_state;
        n_wr_idx     = r_wr_idx;
        n_rd_idx     = r_rd_idx;
        n_held       = r_held;
        n_over       = r_over;
        n_under      = r_under;
        n_left       = r_left;
        n_out_valid  = 1'b0;
        n_out_status = 1'b0;
        n_out_zf     = 1'b0;
        n_out_last   = 1'b0;
        n_out_mem    = 1'b0;
        n_out_fill   = r_held;
        n_out_over   = r_over;
        n_out_under  = r_under;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        o_q_pop      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.opcode == OP_PUSH) begin
                        if (r_held >= i_cfg.cap) begin
                            n_over = r_over + 32'd1;
                        end else begin
                            mem_we   = 1'b1;
                            n_wr_idx = wrap_inc(r_wr_idx, i_cfg.cap);
                            n_held   = r_held + 1'b1;
                        end
                    end else if (i_q_cmd.reject) begin
                        n_out_valid  = 1'b1;
                        n_out_status = 1'b1;
                        n_out_last   = 1'b1;
                    end else begin
                        n_left  = i_q_cmd.frames;
                        n_state = S_RENDER;
                    end
                end
            end
            S_RENDER: begin
                if (r_held != '0) begin
                    mem_re    = 1'b1;
                    n_out_mem = 1'b1;
                    n_rd_idx  = wrap_inc(r_rd_idx, i_cfg.cap);
                    n_held    = r_held - 1'b1;
                end else begin
                    n_out_zf = 1'b1;
                    n_under  = r_under + 32'd1;
                end
                n_out_valid = 1'b1;
                n_out_last  = r_left == FRAMES_W'(1);
                n_out_fill  = n_held;
                n_out_under = n_under;
                n_left      = r_left - 1'b1;
                if (r_left == FRAMES_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A capacity write clears the ring; the user sends it only when idle, unchecked.
        if (i_cfg.clear) begin
            n_wr_idx = '0;
            n_rd_idx = '0;
            n_held   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_held      <= '0;
            r_over      <= '0;
            r_under     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_held      <= n_held;
            r_over      <= n_over;
            r_under     <= n_under;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_zf     <= n_out_zf;
        r_out_last   <= n_out_last;
        r_out_mem    <= n_out_mem;
        r_out_fill   <= n_out_fill;
        r_out_over   <= n_out_over;
        r_out_under  <= n_out_under;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame_mem[r_wr_idx] <= {i_q_cmd.left, i_q_cmd.right};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_frame_mem[r_rd_idx];
        end
    end

    assign o_valid                  = r_out_valid;
    assign o_result.left_sample     = r_out_mem ? r_rd_data[47:24] : 24'sd0;
    assign o_result.right_sample    = r_out_mem ? r_rd_data[23:0]  : 24'sd0;
    assign o_result.status          = r_out_status;
    assign o_result.zero_filled     = r_out_zf;
    assign o_result.last_of_packet  = r_out_last;
    assign o_result.fill_level      = 9'(r_out_fill);
    assign o_result.overrun_count   = r_out_over;
    assign o_result.underrun_count  = r_out_under;

    a_held_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= i_cfg.cap || $past(i_cfg.clear))
        else $error("ring holds more frames than its capacity");

    a_render_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RENDER |-> r_left != '0)
        else $error("render running with no frames left");

    a_empty_gives_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RENDER && r_held == '0 && !i_cfg.clear
        |=> r_out_valid && r_out_zf && r_under == $past(r_under) + 32'd1)
        else $error("empty ring frame was not zero-filled and counted");

    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status |-> r_out_last && !r_out_zf && !r_out_mem)
        else $error("rejected request produced a malformed result");

endmodule

[hdl/usb_audio_ring_packetizer_top.sv]
// Top level of the USB audio ring packetizer: configuration registers and the
// front, queue and back parts. Depends on urp_pkg, urp_front, urp_queue, urp_back.
//
// A command is taken at a rising edge with start high and busy low. A push stores one stereo
// frame (converted to saturated 24-bit samples) in a ring of up to 256 slots and gives no
// result; a render emits one result per frame of the USB packet: 48 frames at 48 kHz, and at
// 44.1 kHz 44 frames, or 45 when the USB frame number ends in the decimal digit 9. A rejected
// render gives a single result with status set. Results appear on o_result for exactly one
// cycle, marked by o_result_valid; the receiver cannot stall them. Commands pass a registered
// front stage and a two-entry queue, so busy rises only when both are full. The back part
// executes a push or a rejected render as it pops it in its idle state, and a render of F frames
// in its render state at one frame per cycle, limited by the single read port of the frame memory.
// Each result of a render is registered, together with its frame memory read, in the render state.
// Configuration writes take effect at once and must be made while no command is in flight;
// writing ring_capacity empties the ring but keeps the overrun and underrun counters.
module usb_audio_ring_packetizer_top import urp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_cmd,
    output logic                  o_result_valid,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [17:0]      r_sample_rate;
    logic [8:0]       r_ring_cap;
    logic [CAP_W-1:0] active_cap;
    t_back_cfg        back_cfg;

    logic             accept;
    logic             front_valid;
    t_cmd             front_cmd;
    logic             q_full;
    logic             q_valid;
    t_cmd             q_cmd;
    logic             q_pop;

    // Register writes; the ring capacity write also clears the ring in the back part.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= RATE_48K;
            r_ring_cap    <= 9'(DEPTH);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[17:0];
                CFG_RING_CAP:    r_ring_cap    <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // A capacity of zero acts as one slot, and anything above the memory depth as the depth.
    always_comb begin
        if (r_ring_cap == '0) begin
            active_cap = CAP_W'(1);
        end else if (32'(r_ring_cap) > DEPTH) begin
            active_cap = CAP_W'(DEPTH);
        end else begin
            active_cap = CAP_W'(r_ring_cap);
        end
        back_cfg.cap   = active_cap;
        back_cfg.clear = i_cfg_we && i_cfg_index == CFG_RING_CAP;
    end

    // The front stage can take a new command unless it holds one that the queue cannot take.
    assign busy   = front_valid && q_full;
    assign accept = start && !busy;

    urp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_cmd),
        .i_sample_rate (r_sample_rate),
        .i_q_full      (q_full),
        .o_valid       (front_valid),
        .o_cmd         (front_cmd)
    );

    urp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    urp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (back_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_result_valid),
        .o_result  (o_result)
    );

endmodule
